/* hdl/assert_macros.svh */
// Assertion macros shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, masked while reset is low.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, masked while reset is low.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

// Holds at every edge, reset included.
`define ASSERT_ALWAYS(label, clk, expr) \
    label: assert property (@(posedge clk) (expr)) \
        else $error("assertion failed");

`endif

/* hdl/scps_pkg.sv */
// Types, widths and helpers for the segment closest point snap pipeline.
package scps_pkg;

    localparam int CW   = 24;          // coordinate width
    localparam int TW   = CW - 1;      // tolerance width
    localparam int DW   = CW + 1;      // difference width
    localparam int SQW  = 2 * DW;      // product of two differences
    localparam int SW   = SQW + 1;     // sum of two products
    localparam int QW   = CW + 2;      // quotient bits produced by the divider
    localparam int PW   = DW + SW;     // full numerator product a * num
    localparam int OW   = QW + 1;      // signed offset width
    localparam int APBW = 32;

    localparam logic [OW-1:0] OFFCAP = OW'(1) << (CW + 1);

    // register select, paddr[2]
    localparam logic REG_CLAMP = 1'b0;
    localparam logic REG_TOL   = 1'b1;

    typedef logic signed [CW-1:0] t_coord;

    typedef struct packed {
        t_coord query_x;
        t_coord query_y;
        t_coord start_x;
        t_coord start_y;
        t_coord start_z;
        t_coord end_x;
        t_coord end_y;
        t_coord end_z;
    } t_query;

    typedef enum logic [2:0] {
        OC_SNAP_START  = 3'd0,
        OC_SNAP_END    = 3'd1,
        OC_INSIDE      = 3'd2,
        OC_EXTRAP      = 3'd3,
        OC_CLAMP_START = 3'd4,
        OC_CLAMP_END   = 3'd5,
        OC_DEGEN       = 3'd6
    } t_outcome;

    typedef struct packed {
        t_coord   found_x;
        t_coord   found_y;
        t_coord   found_z;
        t_outcome outcome;
    } t_result;

    typedef struct packed {
        logic          clamp;
        logic [TW-1:0] tol;
    } t_cfg;

    // endpoints and decided outcome, carried down the pipe
    typedef struct packed {
        t_coord   sx;
        t_coord   sy;
        t_coord   sz;
        t_coord   ex;
        t_coord   ey;
        t_coord   ez;
        t_outcome oc;
    } t_ctx;

    typedef struct packed {
        logic [SW-1:0]      den;
        logic [SW-1:0]      num_mag;
        logic               num_neg;
        logic [2:0][DW-1:0] a_mag;
        logic [2:0]         a_neg;
        t_ctx               ctx;
    } t_front;

    typedef struct packed {
        logic [SW-1:0] rem;
        logic [QW-1:0] q;
        logic [QW-1:0] pl;     // numerator bits not yet shifted in
        logic          neg;
        logic          ovf;
    } t_lane;

    typedef struct packed {
        logic [SW-1:0]  den;
        t_lane [2:0]    lane;
        t_ctx           ctx;
    } t_div;

    function automatic logic signed [DW-1:0] ext_c(input t_coord v);
        return {v[CW-1], v};
    endfunction

    function automatic t_coord sat_coord(input logic signed [OW:0] v);
        if ((&v[OW:CW-1]) || !(|v[OW:CW-1]))
            return v[CW-1:0];
        else if (v[OW])
            return {1'b1, {(CW-1){1'b0}}};
        else
            return {1'b0, {(CW-1){1'b1}}};
    endfunction

endpackage

/* hdl/scps_front.sv */
// Front stages: differences, squares, sums, snap and range classification.
module scps_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  scps_pkg::t_query i_item,
    input  scps_pkg::t_cfg  i_cfg,
    output logic            o_valid,
    output scps_pkg::t_front o_data
);
    import scps_pkg::*;

    // stage 1
    logic                 r1_v;
    logic signed [DW-1:0] r1_dsx, r1_dsy, r1_dex, r1_dey, r1_dx, r1_dy, r1_dz;
    t_ctx                 r1_ctx;
    // stage 2
    logic                  r2_v;
    logic [SQW-1:0]        r2_dsx2, r2_dsy2, r2_dex2, r2_dey2, r2_dx2, r2_dy2;
    logic signed [SQW-1:0] r2_nx, r2_ny;
    logic [2*TW-1:0]       r2_t2;
    logic signed [DW-1:0]  r2_dx, r2_dy, r2_dz;
    t_ctx                  r2_ctx;
    // stage 3
    logic                 r3_v;
    logic [SW-1:0]        r3_ds2, r3_de2, r3_den;
    logic signed [SW-1:0] r3_num;
    logic [2*TW-1:0]      r3_t2;
    logic signed [DW-1:0] r3_dx, r3_dy, r3_dz;
    t_ctx                 r3_ctx;
    // stage 4
    logic     r4_v;
    t_front   r4_d;
    t_outcome n_oc;
    logic     snap_s, snap_e, den0, in_seg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
        end else if (i_en) begin
            r1_v <= i_valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_dsx <= ext_c(i_item.query_x) - ext_c(i_item.start_x);
            r1_dsy <= ext_c(i_item.query_y) - ext_c(i_item.start_y);
            r1_dex <= ext_c(i_item.query_x) - ext_c(i_item.end_x);
            r1_dey <= ext_c(i_item.query_y) - ext_c(i_item.end_y);
            r1_dx  <= ext_c(i_item.end_x) - ext_c(i_item.start_x);
            r1_dy  <= ext_c(i_item.end_y) - ext_c(i_item.start_y);
            r1_dz  <= ext_c(i_item.end_z) - ext_c(i_item.start_z);
            r1_ctx <= '{sx: i_item.start_x, sy: i_item.start_y, sz: i_item.start_z,
                        ex: i_item.end_x, ey: i_item.end_y, ez: i_item.end_z,
                        oc: OC_INSIDE};

            r2_dsx2 <= r1_dsx * r1_dsx;
            r2_dsy2 <= r1_dsy * r1_dsy;
            r2_dex2 <= r1_dex * r1_dex;
            r2_dey2 <= r1_dey * r1_dey;
            r2_dx2  <= r1_dx * r1_dx;
            r2_dy2  <= r1_dy * r1_dy;
            r2_nx   <= r1_dsx * r1_dx;
            r2_ny   <= r1_dsy * r1_dy;
            r2_t2   <= i_cfg.tol * i_cfg.tol;
            r2_dx   <= r1_dx;
            r2_dy   <= r1_dy;
            r2_dz   <= r1_dz;
            r2_ctx  <= r1_ctx;

            r3_ds2 <= {1'b0, r2_dsx2} + {1'b0, r2_dsy2};
            r3_de2 <= {1'b0, r2_dex2} + {1'b0, r2_dey2};
            r3_den <= {1'b0, r2_dx2} + {1'b0, r2_dy2};
            r3_num <= SW'(r2_nx) + SW'(r2_ny);
            r3_t2  <= r2_t2;
            r3_dx  <= r2_dx;
            r3_dy  <= r2_dy;
            r3_dz  <= r2_dz;
            r3_ctx <= r2_ctx;

            r4_d.den      <= r3_den;
            r4_d.num_mag  <= r3_num[SW-1] ? SW'(-r3_num) : SW'(r3_num);
            r4_d.num_neg  <= r3_num[SW-1];
            r4_d.a_mag[0] <= r3_dx[DW-1] ? DW'(-r3_dx) : DW'(r3_dx);
            r4_d.a_mag[1] <= r3_dy[DW-1] ? DW'(-r3_dy) : DW'(r3_dy);
            r4_d.a_mag[2] <= r3_dz[DW-1] ? DW'(-r3_dz) : DW'(r3_dz);
            r4_d.a_neg    <= {r3_dz[DW-1], r3_dy[DW-1], r3_dx[DW-1]};
            r4_d.ctx      <= '{sx: r3_ctx.sx, sy: r3_ctx.sy, sz: r3_ctx.sz,
                               ex: r3_ctx.ex, ey: r3_ctx.ey, ez: r3_ctx.ez, oc: n_oc};
        end
    end

    // classification; start snap wins over end snap
    always_comb begin
        snap_s = r3_ds2 < SW'(r3_t2);
        snap_e = r3_de2 < SW'(r3_t2);
        den0   = (r3_den == '0);
        in_seg = !r3_num[SW-1] && (SW'(r3_num) <= r3_den);
        if (snap_s)
            n_oc = OC_SNAP_START;
        else if (snap_e)
            n_oc = OC_SNAP_END;
        else if (den0)
            n_oc = OC_DEGEN;
        else if (in_seg)
            n_oc = OC_INSIDE;
        else if (!i_cfg.clamp)
            n_oc = OC_EXTRAP;
        else if (r3_num[SW-1])
            n_oc = OC_CLAMP_START;
        else
            n_oc = OC_CLAMP_END;
    end

    assign o_valid = r4_v;
    assign o_data  = r4_d;

endmodule

/* hdl/scps_prod.sv */
// Numerator products a*|num| in split halves and divider setup.
module scps_prod (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  scps_pkg::t_front i_data,
    output logic             o_valid,
    output scps_pkg::t_div   o_data
);
    import scps_pkg::*;

    logic                    r5_v, r6_v, r7_v;
    logic [2:0][SW-1:0]      r5_lo;
    logic [2:0][SW-QW+DW-1:0] r5_hi;
    logic [2:0]              r5_neg, r6_neg;
    logic [SW-1:0]           r5_den, r6_den;
    t_ctx                    r5_ctx, r6_ctx;
    logic [2:0][PW-1:0]      r6_p;
    t_div                    r7_d;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_v <= 1'b0;
            r6_v <= 1'b0;
            r7_v <= 1'b0;
        end else if (i_en) begin
            r5_v <= i_valid;
            r6_v <= r5_v;
            r7_v <= r6_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r5_lo[i]  <= i_data.a_mag[i] * i_data.num_mag[QW-1:0];
                r5_hi[i]  <= i_data.a_mag[i] * i_data.num_mag[SW-1:QW];
                r5_neg[i] <= i_data.a_neg[i] ^ i_data.num_neg;

                r6_p[i]   <= {r5_hi[i], {QW{1'b0}}} + PW'(r5_lo[i]);
                r6_neg[i] <= r5_neg[i];

                // quotient >= 2^QW exactly when the upper numerator part reaches den
                r7_d.lane[i].rem <= SW'(r6_p[i][PW-1:QW]);
                r7_d.lane[i].pl  <= r6_p[i][QW-1:0];
                r7_d.lane[i].q   <= '0;
                r7_d.lane[i].neg <= r6_neg[i];
                r7_d.lane[i].ovf <= SW'(r6_p[i][PW-1:QW]) >= r6_den;
            end
            r5_den   <= i_data.den;
            r5_ctx   <= i_data.ctx;
            r6_den   <= r5_den;
            r6_ctx   <= r5_ctx;
            r7_d.den <= r6_den;
            r7_d.ctx <= r6_ctx;
        end
    end

    assign o_valid = r7_v;
    assign o_data  = r7_d;

endmodule

/* hdl/scps_div_step.sv */
// One restoring-division step: one quotient bit on each of three lanes.
module scps_div_step (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  scps_pkg::t_div i_data,
    output logic           o_valid,
    output scps_pkg::t_div o_data
);
    import scps_pkg::*;

    logic   r_v;
    t_div   r_d;
    t_div   n_d;
    logic [SW:0] trial [3];
    logic [SW:0] diff  [3];
    logic        ge    [3];

    always_comb begin
        n_d = i_data;
        for (int i = 0; i < 3; i++) begin
            trial[i] = {i_data.lane[i].rem, i_data.lane[i].pl[QW-1]};
            diff[i]  = trial[i] - {1'b0, i_data.den};
            ge[i]    = trial[i] >= {1'b0, i_data.den};
            n_d.lane[i].rem = ge[i] ? diff[i][SW-1:0] : trial[i][SW-1:0];
            n_d.lane[i].q   = {i_data.lane[i].q[QW-2:0], ge[i]};
            n_d.lane[i].pl  = {i_data.lane[i].pl[QW-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_v <= 1'b0;
        else if (i_en)
            r_v <= i_valid;
    end

    always_ff @(posedge i_clk) begin
        if (i_en)
            r_d <= n_d;
    end

    assign o_valid = r_v;
    assign o_data  = r_d;

endmodule

/* hdl/scps_back.sv */
// Back stages: rounding and capping of offsets, final sum, result selection.
module scps_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  scps_pkg::t_div    i_data,
    output logic              o_valid,
    output scps_pkg::t_result o_data
);
    import scps_pkg::*;

    logic                        r1_v, r2_v;
    logic signed [2:0][OW-1:0]   r1_off;
    t_ctx                        r1_ctx;
    t_result                     r2_d;
    logic [OW-1:0]               qr  [3];
    logic [OW-1:0]               qm  [3];
    logic                        rb  [3];
    logic signed [OW:0]          sum [3];
    t_coord                      pt  [3];

    // round half away from zero on the magnitude, then cap
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            rb[i] = {i_data.lane[i].rem, 1'b0} >= {1'b0, i_data.den};
            qr[i] = {1'b0, i_data.lane[i].q} + OW'(rb[i]);
            qm[i] = (i_data.lane[i].ovf || qr[i] > OFFCAP) ? OFFCAP : qr[i];
        end
    end

    always_comb begin
        sum[0] = (OW+1)'(ext_c(r1_ctx.sx)) + (OW+1)'(signed'(r1_off[0]));
        sum[1] = (OW+1)'(ext_c(r1_ctx.sy)) + (OW+1)'(signed'(r1_off[1]));
        sum[2] = (OW+1)'(ext_c(r1_ctx.sz)) + (OW+1)'(signed'(r1_off[2]));
        for (int i = 0; i < 3; i++)
            pt[i] = sat_coord(sum[i]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
        end else if (i_en) begin
            r1_v <= i_valid;
            r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++)
                r1_off[i] <= i_data.lane[i].neg ? OW'(-qm[i]) : qm[i];
            r1_ctx <= i_data.ctx;

            r2_d.outcome <= r1_ctx.oc;
            case (r1_ctx.oc) inside
                OC_SNAP_START, OC_CLAMP_START, OC_DEGEN: begin
                    r2_d.found_x <= r1_ctx.sx;
                    r2_d.found_y <= r1_ctx.sy;
                    r2_d.found_z <= r1_ctx.sz;
                end
                OC_SNAP_END, OC_CLAMP_END: begin
                    r2_d.found_x <= r1_ctx.ex;
                    r2_d.found_y <= r1_ctx.ey;
                    r2_d.found_z <= r1_ctx.ez;
                end
                default: begin
                    r2_d.found_x <= pt[0];
                    r2_d.found_y <= pt[1];
                    r2_d.found_z <= pt[2];
                end
            endcase
        end
    end

    assign o_valid = r2_v;
    assign o_data  = r2_d;

endmodule

/* hdl/segment_closest_point_snap.sv */
// Segment closest point snap: top level with config registers and pipeline.
//
// Finds the point on a 3D segment's line closest to a 2D query, in signed
// 24-bit fixed point (8 fraction bits). A query closer than snap_tolerance
// to the start snaps to the start, else to the end; a zero-length segment
// returns the start; otherwise the query is projected and x, y, z are
// start + round(d * num / den). Beyond the segment the result is either
// extrapolated or, with clamp_to_ends set, the nearer endpoint. One
// transfer is taken every cycle while o_stall is low; each result passes
// in order through the 26-step pipelined divider (one quotient bit per
// stage, three lanes for x, y, z). The pipe moves as one: when the
// output register holds a result and i_stall is high, every stage holds and
// o_stall is raised. Registers: clamp_to_ends at byte 0 (reset 1),
// snap_tolerance at byte 4 (reset 0); change them only while the block is
// empty.
module segment_closest_point_snap (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  scps_pkg::t_query   i_item,
    output logic               o_valid,
    input  logic               i_stall,
    output scps_pkg::t_result  o_result,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import scps_pkg::*;

    logic          r_clamp;
    logic [TW-1:0] r_tol;
    t_cfg          cfg;
    logic          en;

    logic     front_v;
    t_front   front_d;
    logic     div_v [QW+1];
    t_div     div_d [QW+1];

    // APB: always ready, word select on paddr[2]
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clamp <= 1'b1;
            r_tol   <= '0;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[2])
                REG_CLAMP: r_clamp <= pwdata[0];
                REG_TOL:   r_tol   <= pwdata[TW-1:0];
                default:   ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_CLAMP: prdata = {{(APBW-1){1'b0}}, r_clamp};
            REG_TOL:   prdata = {{(APBW-TW){1'b0}}, r_tol};
            default:   prdata = '0;
        endcase
    end

    assign cfg = '{clamp: r_clamp, tol: r_tol};

    // whole pipe advances unless a finished result is held by the sink
    assign en      = !(o_valid && i_stall);
    assign o_stall = !en;

    scps_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_valid),
        .i_item  (i_item),
        .i_cfg   (cfg),
        .o_valid (front_v),
        .o_data  (front_d)
    );

    scps_prod u_prod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (front_v),
        .i_data  (front_d),
        .o_valid (div_v[0]),
        .o_data  (div_d[0])
    );

    // divider chain, one quotient bit per stage
    for (genvar k = 0; k < QW; k++) begin : g_div
        scps_div_step u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (div_v[k]),
            .i_data  (div_d[k]),
            .o_valid (div_v[k+1]),
            .o_data  (div_d[k+1])
        );
    end

    scps_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (div_v[QW]),
        .i_data  (div_d[QW]),
        .o_valid (o_valid),
        .o_data  (o_result)
    );

endmodule

/* hdl/scps_checker.sv */
// Port-level checker for the snap pipeline and its bind.
`include "assert_macros.svh"

module scps_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_stall,
    input logic              o_valid,
    input logic              i_stall,
    input scps_pkg::t_result o_result,
    input logic              pready
);
    // a held result must not move
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_result))
    // upstream is only held back by a held result
    `ASSERT_IMPL(a_stall_cause, i_clk, i_rst_n, o_stall, o_valid && i_stall)
    // the output register is empty right after reset
    `ASSERT_IMPL(a_reset_empty, i_clk, i_rst_n, !$past(i_rst_n), !o_valid)
    `ASSERT_ALWAYS(a_apb_ready, i_clk, pready)
endmodule

bind segment_closest_point_snap scps_checker u_scps_checker (.*);
